@@ hdl/bet_pkg.sv @@
// Shared types, codes and helpers for the BSON element tokenizer.
package bet_pkg;

    localparam int CNT_W = 31;

    typedef enum logic [2:0]
    {
        PH_SIZE,
        PH_TYPE,
        PH_KEY,
        PH_LEN,
        PH_SUB,
        PH_VAL,
        PH_SKIP
    } phase_t;

    localparam logic [7:0] T_END    = 8'h00;
    localparam logic [7:0] T_DOUBLE = 8'h01;
    localparam logic [7:0] T_STRING = 8'h02;
    localparam logic [7:0] T_DOC    = 8'h03;
    localparam logic [7:0] T_ARRAY  = 8'h04;
    localparam logic [7:0] T_BINARY = 8'h05;
    localparam logic [7:0] T_BOOL   = 8'h08;
    localparam logic [7:0] T_DATE   = 8'h09;
    localparam logic [7:0] T_NULL   = 8'h0A;
    localparam logic [7:0] T_INT32  = 8'h10;
    localparam logic [7:0] T_TSTAMP = 8'h11;
    localparam logic [7:0] T_INT64  = 8'h12;

    localparam logic [3:0] ROLE_SIZE    = 4'd0;
    localparam logic [3:0] ROLE_TYPE    = 4'd1;
    localparam logic [3:0] ROLE_KEY     = 4'd2;
    localparam logic [3:0] ROLE_KEY_END = 4'd3;
    localparam logic [3:0] ROLE_LEN     = 4'd4;
    localparam logic [3:0] ROLE_SUB     = 4'd5;
    localparam logic [3:0] ROLE_VAL     = 4'd6;
    localparam logic [3:0] ROLE_SKIP    = 4'd7;
    localparam logic [3:0] ROLE_END     = 4'd8;
    localparam logic [3:0] ROLE_IGNORED = 4'd9;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_LENGTH  = 2'd2;

    localparam logic [CNT_W-1:0] SIZE_BYTES = CNT_W'(4);
    localparam logic [CNT_W-1:0] LEN_BYTES  = CNT_W'(4);

    typedef struct packed
    {
        logic [3:0]       byte_role;
        logic [7:0]       data_out;
        logic [7:0]       element_type;
        logic             element_done;
        logic [63:0]      scalar_value;
        logic [CNT_W-1:0] payload_length;
        logic [1:0]       error_code;
    } result_t;

    function automatic logic known_type(input logic [7:0] t);
        return t == T_DOUBLE || t == T_STRING || t == T_DOC || t == T_ARRAY ||
               t == T_BINARY || t == T_BOOL || t == T_DATE || t == T_NULL ||
               t == T_INT32 || t == T_TSTAMP || t == T_INT64;
    endfunction

    function automatic logic [3:0] scalar_size(input logic [7:0] t);
        logic [3:0] n;
        n = 4'd0;
        if (t == T_INT32)
        begin
            n = 4'd4;
        end
        else if (t == T_BOOL)
        begin
            n = 4'd1;
        end
        else if (t == T_DOUBLE || t == T_DATE || t == T_TSTAMP || t == T_INT64)
        begin
            n = 4'd8;
        end
        return n;
    endfunction

endpackage

@@ hdl/bson_element_tokenizer_unit.sv @@
// BSON element tokenizer: byte-wide document parser with a two-entry result buffer.
//
// Input channel: one document byte per beat (data_byte) with doc_start on the
// first size byte and doc_last on the last byte within the document length.
// Output channel: one result beat per input beat, in order, giving the role
// of the byte, its echo, the element type, completion, the assembled scalar,
// the accepted payload length and an error code.
// Each byte's result is registered before it is presented on the output channel.
// Throughput: one byte per cycle while in_stall is low; the phase machine and its
// counters update in the same cycle the byte is taken.
// The result side has an output register and a skid register; when the
// receiver stalls, one more byte is taken into the skid register and in_stall
// then rises until the output register drains.
// After reset the parser waits for the four size bytes, and doc_start
// restarts it at any byte. After the end byte, an error or doc_last, bytes
// are reported as ignored until the next doc_start.
module bson_element_tokenizer_unit
    import bet_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    input  logic             doc_start,
    input  logic             doc_last,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [3:0]       byte_role,
    output logic [7:0]       data_out,
    output logic [7:0]       element_type,
    output logic             element_done,
    output logic [63:0]      scalar_value,
    output logic [CNT_W-1:0] payload_length,
    output logic [1:0]       error_code
);

    phase_t           phase_reg, phase_next, phase_cur;
    logic [7:0]       type_reg, type_next, type_cur;
    logic [CNT_W-1:0] rem_reg, rem_next, rem_cur;
    logic [31:0]      len_reg, len_next, len_cur;
    logic [63:0]      val_reg, val_next, val_cur;
    logic             stop_reg, stop_next, stop_cur;
    logic             stop_case;

    logic             accept;
    logic [31:0]      len_asm;
    logic [63:0]      val_asm;
    logic             len_bad;
    logic             is_scalar;
    logic             rem_last;
    logic [31:0]      len_minus;
    result_t          res;

    result_t          out_reg, skid_reg;
    logic             out_valid_reg, skid_valid_reg;
    logic             out_free;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;

    // doc_start restarts the parser on this very byte
    assign phase_cur = doc_start ? PH_SIZE    : phase_reg;
    assign type_cur  = doc_start ? T_END      : type_reg;
    assign rem_cur   = doc_start ? SIZE_BYTES : rem_reg;
    assign len_cur   = doc_start ? 32'd0      : len_reg;
    assign val_cur   = doc_start ? 64'd0      : val_reg;
    assign stop_cur  = doc_start ? 1'b0       : stop_reg;

    assign len_asm   = len_cur | (32'(data_byte) << {2'(LEN_BYTES - rem_cur), 3'b000});
    assign val_asm   = val_cur | (64'(data_byte) << {len_cur[2:0], 3'b000});
    assign is_scalar = scalar_size(type_cur) != 4'd0;
    assign rem_last  = rem_cur <= CNT_W'(1);
    assign len_minus = len_asm - 32'd4;

    always_comb
    begin
        if (type_cur == T_STRING)
        begin
            len_bad = len_asm[31] || len_asm == 32'd0;
        end
        else if (type_cur == T_BINARY)
        begin
            len_bad = len_asm[31];
        end
        else
        begin
            len_bad = len_asm[31] || len_asm < 32'd5;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_cur;
        type_next  = type_cur;
        rem_next   = rem_cur;
        len_next   = len_cur;
        val_next   = val_cur;
        stop_case  = stop_cur;
        if (!stop_cur)
        begin
            unique case (phase_cur)
                PH_SIZE:
                begin
                    if (!rem_last)
                    begin
                        rem_next = rem_cur - CNT_W'(1);
                    end
                    else
                    begin
                        rem_next   = '0;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    if (data_byte == T_END)
                    begin
                        stop_case = 1'b1;
                    end
                    else if (known_type(data_byte))
                    begin
                        type_next  = data_byte;
                        val_next   = '0;
                        len_next   = '0;
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        stop_case = 1'b1;
                    end
                end
                PH_KEY:
                begin
                    if (data_byte == 8'd0)
                    begin
                        if (is_scalar)
                        begin
                            rem_next   = CNT_W'(scalar_size(type_cur));
                            len_next   = '0;
                            phase_next = PH_VAL;
                        end
                        else if (type_cur == T_NULL)
                        begin
                            phase_next = PH_TYPE;
                        end
                        else
                        begin
                            rem_next   = LEN_BYTES;
                            len_next   = '0;
                            phase_next = PH_LEN;
                        end
                    end
                end
                PH_LEN:
                begin
                    len_next = len_asm;
                    if (!rem_last)
                    begin
                        rem_next = rem_cur - CNT_W'(1);
                    end
                    else
                    begin
                        rem_next = '0;
                        if (len_bad)
                        begin
                            stop_case = 1'b1;
                        end
                        else if (type_cur == T_STRING)
                        begin
                            rem_next   = len_asm[CNT_W-1:0];
                            phase_next = PH_VAL;
                        end
                        else if (type_cur == T_BINARY)
                        begin
                            phase_next = PH_SUB;
                        end
                        else
                        begin
                            rem_next   = len_minus[CNT_W-1:0];
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_SUB:
                begin
                    if (len_cur == 32'd0)
                    begin
                        phase_next = PH_TYPE;
                    end
                    else
                    begin
                        rem_next   = len_cur[CNT_W-1:0];
                        phase_next = PH_VAL;
                    end
                end
                PH_VAL:
                begin
                    if (is_scalar)
                    begin
                        val_next = val_asm;
                        len_next = len_cur + 32'd1;
                    end
                    if (!rem_last)
                    begin
                        rem_next = rem_cur - CNT_W'(1);
                    end
                    else
                    begin
                        rem_next   = '0;
                        phase_next = PH_TYPE;
                    end
                end
                PH_SKIP:
                begin
                    if (!rem_last)
                    begin
                        rem_next = rem_cur - CNT_W'(1);
                    end
                    else
                    begin
                        rem_next   = '0;
                        phase_next = PH_TYPE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        stop_next = stop_case || doc_last;
    end

    // result for this byte
    always_comb
    begin
        res = '0;
        res.byte_role = ROLE_IGNORED;
        if (!stop_cur)
        begin
            unique case (phase_cur)
                PH_SIZE:
                begin
                    res.byte_role = ROLE_SIZE;
                end
                PH_TYPE:
                begin
                    res.element_type = data_byte;
                    if (data_byte == T_END)
                    begin
                        res.byte_role = ROLE_END;
                    end
                    else
                    begin
                        res.byte_role = ROLE_TYPE;
                        if (!known_type(data_byte))
                        begin
                            res.error_code = ERR_UNKNOWN;
                        end
                    end
                end
                PH_KEY:
                begin
                    res.element_type = type_cur;
                    if (data_byte != 8'd0)
                    begin
                        res.byte_role = ROLE_KEY;
                        res.data_out  = data_byte;
                    end
                    else
                    begin
                        res.byte_role    = ROLE_KEY_END;
                        res.element_done = !is_scalar && type_cur == T_NULL;
                    end
                end
                PH_LEN:
                begin
                    res.byte_role    = ROLE_LEN;
                    res.element_type = type_cur;
                    if (rem_last)
                    begin
                        if (len_bad)
                        begin
                            res.error_code = ERR_LENGTH;
                        end
                        else
                        begin
                            res.payload_length = len_asm[CNT_W-1:0];
                        end
                    end
                end
                PH_SUB:
                begin
                    res.byte_role      = ROLE_SUB;
                    res.data_out       = data_byte;
                    res.element_type   = type_cur;
                    res.payload_length = len_cur[CNT_W-1:0];
                    res.element_done   = len_cur == 32'd0;
                end
                PH_VAL:
                begin
                    res.byte_role    = ROLE_VAL;
                    res.data_out     = data_byte;
                    res.element_type = type_cur;
                    if (!is_scalar)
                    begin
                        res.payload_length = len_cur[CNT_W-1:0];
                    end
                    if (rem_last)
                    begin
                        res.element_done = 1'b1;
                        if (is_scalar)
                        begin
                            if (type_cur == T_INT32)
                            begin
                                res.scalar_value = {{32{val_asm[31]}}, val_asm[31:0]};
                            end
                            else
                            begin
                                res.scalar_value = val_asm;
                            end
                        end
                    end
                end
                PH_SKIP:
                begin
                    res.byte_role      = ROLE_SKIP;
                    res.data_out       = data_byte;
                    res.element_type   = type_cur;
                    res.payload_length = len_cur[CNT_W-1:0];
                    res.element_done   = rem_last;
                end
                default:
                begin
                end
            endcase
            // flag an element cut short by the document end
            if (doc_last && !stop_case && phase_next != PH_TYPE && phase_next != PH_SIZE)
            begin
                res.error_code = ERR_LENGTH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIZE;
            type_reg  <= T_END;
            rem_reg   <= SIZE_BYTES;
            len_reg   <= '0;
            val_reg   <= '0;
            stop_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            rem_reg   <= rem_next;
            len_reg   <= len_next;
            val_reg   <= val_next;
            stop_reg  <= stop_next;
        end
    end

    // output register with skid: load the output register when it is empty or draining
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= res;
            end
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign byte_role      = out_reg.byte_role;
    assign data_out       = out_reg.data_out;
    assign element_type   = out_reg.element_type;
    assign element_done   = out_reg.element_done;
    assign scalar_value   = out_reg.scalar_value;
    assign payload_length = out_reg.payload_length;
    assign error_code     = out_reg.error_code;

endmodule
